FILE: hdl/avw_pkg.sv
`timescale 1ns / 1ps
// Package for the Adams-Bashforth velocity weigher: transaction types, method and order codes,
// coefficient table and width constants. Has no dependencies.
package avw_pkg;

  localparam int unsigned VelW           = 32;
  localparam int unsigned MethodW        = 3;
  localparam int unsigned OrderW         = 3;
  localparam int unsigned FillW          = 2;
  localparam int unsigned NumAxes        = 3;
  localparam int unsigned NumTaps        = 4;
  localparam int unsigned NumPrior       = 3;
  localparam int unsigned LaneStages     = 6;
  localparam int unsigned DefSampleWidth = 32;

  typedef enum logic [MethodW-1:0] {
    MethodEuler    = 3'd0,
    MethodAb2      = 3'd1,
    MethodAb3      = 3'd2,
    MethodAb4      = 3'd3,
    MethodAdaptive = 3'd4
  } method_e;

  typedef enum logic [1:0] {
    OrdEuler = 2'd0,
    OrdAb2   = 2'd1,
    OrdAb3   = 2'd2,
    OrdAb4   = 2'd3
  } order_e;

  typedef struct packed {
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic signed [VelW-1:0] vel_z;
    logic                   restart;
  } in_item_t;

  typedef struct packed {
    logic signed [VelW-1:0] out_x;
    logic signed [VelW-1:0] out_y;
    logic signed [VelW-1:0] out_z;
    logic                   clipped;
    logic                   history_short;
    logic [OrderW-1:0]      order_used;
  } out_item_t;

  typedef struct packed {
    order_e ord;
    logic   hist_short;
  } meta_t;

  localparam logic signed [7:0] CoefTab [4][4] = '{
    '{8'sd1,  8'sd0,   8'sd0,  8'sd0},
    '{8'sd3,  -8'sd1,  8'sd0,  8'sd0},
    '{8'sd23, -8'sd16, 8'sd5,  8'sd0},
    '{8'sd55, -8'sd59, 8'sd37, -8'sd9}
  };

  function automatic logic signed [7:0] coef(order_e ord, logic [1:0] tap);
    return CoefTab[ord][tap];
  endfunction

  function automatic int unsigned eff_width(int unsigned sample_width);
    return (sample_width < VelW) ? sample_width : VelW;
  endfunction

endpackage

FILE: hdl/avw_window.sv
`timescale 1ns / 1ps
// History window: method register, sliding window of three earlier samples, fill count and
// order selection, registered into the first pipeline stage. Depends on avw_pkg.
module avw_window #(
  parameter int unsigned SAMPLE_WIDTH = avw_pkg::DefSampleWidth,
  localparam int unsigned EffW = avw_pkg::eff_width(SAMPLE_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [avw_pkg::MethodW-1:0]   cfg_data_i,
  input  logic                          accept_i,
  input  avw_pkg::in_item_t             in_data_i,
  output logic signed [EffW-1:0]        smp_o [avw_pkg::NumAxes][avw_pkg::NumTaps],
  output avw_pkg::meta_t                meta_o
);
  import avw_pkg::*;

  logic [MethodW-1:0]     method_q;
  logic [FillW-1:0]       fill_q, fill_d, fill_eff;
  logic signed [EffW-1:0] prior_q [NumPrior][NumAxes];
  logic signed [EffW-1:0] cur [NumAxes];
  logic signed [EffW-1:0] smp_q [NumAxes][NumTaps];
  meta_t                  meta_q, meta_d;

  assign cur[0] = in_data_i.vel_x[EffW-1:0];
  assign cur[1] = in_data_i.vel_y[EffW-1:0];
  assign cur[2] = in_data_i.vel_z[EffW-1:0];

  assign fill_eff = in_data_i.restart ? '0 : fill_q;

  always_comb begin
    if (method_q <= MethodAb4) begin
      meta_d.ord        = order_e'(method_q[1:0]);
      meta_d.hist_short = (method_q[1:0] > fill_eff);
    end else begin
      meta_d.ord        = order_e'(fill_eff);
      meta_d.hist_short = 1'b0;
    end
  end

  always_comb begin
    if (in_data_i.restart) begin
      fill_d = FillW'(1);
    end else if (fill_q == FillW'(NumPrior)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= MethodEuler;
    end else if (cfg_valid_i) begin
      method_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int k = 0; k < NumPrior; k++) begin
        for (int a = 0; a < NumAxes; a++) begin
          prior_q[k][a] <= '0;
        end
      end
    end else if (accept_i) begin
      fill_q <= fill_d;
      for (int a = 0; a < NumAxes; a++) begin
        prior_q[0][a] <= cur[a];
        prior_q[1][a] <= in_data_i.restart ? '0 : prior_q[0][a];
        prior_q[2][a] <= in_data_i.restart ? '0 : prior_q[1][a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      meta_q <= meta_d;
      for (int a = 0; a < NumAxes; a++) begin
        smp_q[a][0] <= cur[a];
        for (int k = 1; k < NumTaps; k++) begin
          smp_q[a][k] <= in_data_i.restart ? '0 : prior_q[k-1][a];
        end
      end
    end
  end

  assign smp_o  = smp_q;
  assign meta_o = meta_q;

  a_restart_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_data_i.restart |=> fill_q == FillW'(1))
    else $error("fill count not one after a restarting transaction");

  a_adaptive_not_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && method_q >= MethodAdaptive |=> !meta_q.hist_short)
    else $error("short history flagged in adaptive mode");

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> prior_q[0][0] == $past(cur[0]) && smp_q[0][0] == $past(cur[0]))
    else $error("newest sample did not enter the window");

endmodule

FILE: hdl/avw_lane.sv
`timescale 1ns / 1ps
// One axis lane: weighted tap sum, magnitude, division by the order's denominator with
// truncation toward zero, and saturation, over six stages. Depends on avw_pkg.
module avw_lane #(
  parameter int unsigned SAMPLE_WIDTH = avw_pkg::DefSampleWidth,
  localparam int unsigned EffW = avw_pkg::eff_width(SAMPLE_WIDTH)
) (
  input  logic                                clk_i,
  input  logic signed [EffW-1:0]              smp_i [avw_pkg::NumTaps],
  input  avw_pkg::order_e                     ord_i,
  input  logic [avw_pkg::LaneStages-1:0]      en_i,
  output logic signed [EffW-1:0]              res_o,
  output logic                                clip_o
);
  import avw_pkg::*;

  localparam int unsigned AccW = EffW + 8;
  localparam int unsigned MagW = EffW + 7;
  localparam int unsigned XW   = EffW + 4;
  localparam int unsigned HW   = (XW + 1) / 2;
  localparam int unsigned PW   = 4 * HW;
  localparam logic [63:0] RecipFull = (64'd1 << (XW + 1)) / 64'd3;
  localparam logic [2*HW-1:0] Recip = RecipFull[2*HW-1:0];
  localparam logic [XW-1:0] Lim = XW'(1) << (EffW - 1);
  localparam logic signed [EffW-1:0] MaxV = {1'b0, {(EffW-1){1'b1}}};
  localparam logic signed [EffW-1:0] MinV = {1'b1, {(EffW-1){1'b0}}};

  logic signed [AccW-1:0] acc_d, acc_q;
  order_e                 ord1_q, ord2_q, ord3_q, ord4_q;
  logic [AccW-1:0]        mag_full;
  logic [MagW-1:0]        mag;
  logic [XW-1:0]          x2_d, x2_q, x3_q, x4_q;
  logic                   neg2_q, neg3_q, neg4_q, neg5_q;
  logic [HW-1:0]          xh, xl;
  logic [2*HW-1:0]        pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [PW-1:0]          psum;
  logic [XW-1:0]          q4_d, q4_q, q5_d, q5_q;
  logic [XW+1:0]          three_q, rem;
  logic                   clip_d, clip_q;
  logic signed [EffW-1:0] res_d, res_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < NumTaps; k++) begin
      acc_d = acc_d + AccW'(smp_i[k]) * AccW'(coef(ord_i, 2'(k)));
    end
  end

  assign mag_full = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign mag      = mag_full[MagW-1:0];

  always_comb begin
    unique case (ord1_q)
      OrdEuler: x2_d = XW'(mag);
      OrdAb2:   x2_d = XW'(mag >> 1);
      OrdAb3:   x2_d = XW'(mag >> 2);
      OrdAb4:   x2_d = XW'(mag >> 3);
      default:  x2_d = XW'(mag);
    endcase
  end

  assign xh = HW'(x2_q >> HW);
  assign xl = x2_q[HW-1:0];

  assign psum = (PW'(pp_hh_q) << (2 * HW)) + (PW'(pp_hl_q) << HW)
              + (PW'(pp_lh_q) << HW) + PW'(pp_ll_q);
  assign q4_d = XW'(psum >> (XW + 1));

  assign three_q = {q4_q, 1'b0} + (XW + 2)'(q4_q);
  assign rem     = (XW + 2)'(x4_q) - three_q;

  always_comb begin
    unique case (ord4_q)
      OrdAb3, OrdAb4: q5_d = (rem >= (XW + 2)'(3)) ? q4_q + XW'(1) : q4_q;
      default:        q5_d = x4_q;
    endcase
  end

  assign clip_d = neg5_q ? (q5_q > Lim) : (q5_q >= Lim);
  assign res_d  = clip_d ? (neg5_q ? MinV : MaxV)
                         : (neg5_q ? -$signed(q5_q[EffW-1:0]) : $signed(q5_q[EffW-1:0]));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      acc_q  <= acc_d;
      ord1_q <= ord_i;
    end
    if (en_i[1]) begin
      x2_q   <= x2_d;
      neg2_q <= acc_q[AccW-1];
      ord2_q <= ord1_q;
    end
    if (en_i[2]) begin
      pp_hh_q <= (2 * HW)'(xh) * (2 * HW)'(Recip[2*HW-1:HW]);
      pp_hl_q <= (2 * HW)'(xh) * (2 * HW)'(Recip[HW-1:0]);
      pp_lh_q <= (2 * HW)'(xl) * (2 * HW)'(Recip[2*HW-1:HW]);
      pp_ll_q <= (2 * HW)'(xl) * (2 * HW)'(Recip[HW-1:0]);
      x3_q    <= x2_q;
      neg3_q  <= neg2_q;
      ord3_q  <= ord2_q;
    end
    if (en_i[3]) begin
      q4_q   <= q4_d;
      x4_q   <= x3_q;
      neg4_q <= neg3_q;
      ord4_q <= ord3_q;
    end
    if (en_i[4]) begin
      q5_q   <= q5_d;
      neg5_q <= neg4_q;
    end
    if (en_i[5]) begin
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

  assign res_o  = res_q;
  assign clip_o = clip_q;

endmodule

FILE: hdl/avw_merge.sv
`timescale 1ns / 1ps
// Merging stage: combines the three lane results, their saturation flags and the order
// information into the registered result transaction. Depends on avw_pkg.
module avw_merge #(
  parameter int unsigned SAMPLE_WIDTH = avw_pkg::DefSampleWidth,
  localparam int unsigned EffW = avw_pkg::eff_width(SAMPLE_WIDTH)
) (
  input  logic                          clk_i,
  input  logic signed [EffW-1:0]        res_i [avw_pkg::NumAxes],
  input  logic [avw_pkg::NumAxes-1:0]   clip_i,
  input  avw_pkg::meta_t                meta_i,
  input  logic                          en_i,
  output avw_pkg::out_item_t            out_o
);
  import avw_pkg::*;

  out_item_t out_d, out_q;

  always_comb begin
    out_d.out_x         = VelW'(res_i[0]);
    out_d.out_y         = VelW'(res_i[1]);
    out_d.out_z         = VelW'(res_i[2]);
    out_d.clipped       = |clip_i;
    out_d.history_short = meta_i.hist_short;
    out_d.order_used    = OrderW'(meta_i.ord) + OrderW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: hdl/adams_bashforth_velocity_weigher_unit.sv
`timescale 1ns / 1ps
// Adams-Bashforth velocity weigher, top level: window, three axis lanes and merging stage.
// A transaction passes the window register, the lane stages and the merge register in turn.
// Throughput: one transaction per cycle while the output is not stalled; eight pipeline registers, each of which holds
// while its successor is full and stalled, so empty stages close up under back-pressure.
// Reset clears the history window, fill count, method register (Euler) and all stage valids.
// Depends on avw_pkg, avw_window, avw_lane and avw_merge.
module adams_bashforth_velocity_weigher_unit #(
  parameter int unsigned SAMPLE_WIDTH = avw_pkg::DefSampleWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [avw_pkg::MethodW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  avw_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output avw_pkg::out_item_t            out_data_o
);
  import avw_pkg::*;

  localparam int unsigned EffW   = eff_width(SAMPLE_WIDTH);
  localparam int unsigned NumStg = LaneStages + 2;

  logic [NumStg-1:0]      v_q, v_d;
  logic [NumStg:0]        en;
  logic                   accept;
  logic signed [EffW-1:0] win_smp [NumAxes][NumTaps];
  meta_t                  win_meta;
  meta_t                  meta_q [LaneStages];
  logic signed [EffW-1:0] lane_res [NumAxes];
  logic [NumAxes-1:0]     lane_clip;

  assign en[NumStg] = !out_stall_i;

  for (genvar g = 0; g < NumStg; g++) begin : g_ctrl
    assign en[g] = !v_q[g] || en[g+1];
    if (g == 0) begin : g_first
      assign v_d[g] = en[g] ? in_valid_i : v_q[g];
    end else begin : g_rest
      assign v_d[g] = en[g] ? v_q[g-1] : v_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign accept      = in_valid_i && en[0];
  assign in_stall_o  = !en[0];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = v_q[NumStg-1];

  avw_window #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .smp_o       (win_smp),
    .meta_o      (win_meta)
  );

  for (genvar g = 0; g < LaneStages; g++) begin : g_meta
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[g+1]) begin
          meta_q[g] <= win_meta;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en[g+1]) begin
          meta_q[g] <= meta_q[g-1];
        end
      end
    end
  end

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    avw_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane (
      .clk_i  (clk_i),
      .smp_i  (win_smp[a]),
      .ord_i  (win_meta.ord),
      .en_i   (en[LaneStages:1]),
      .res_o  (lane_res[a]),
      .clip_o (lane_clip[a])
    );
  end

  avw_merge #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_merge (
    .clk_i  (clk_i),
    .res_i  (lane_res),
    .clip_i (lane_clip),
    .meta_i (meta_q[LaneStages-1]),
    .en_i   (en[NumStg-1]),
    .out_o  (out_data_o)
  );

  a_stall_only_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.order_used != '0 && out_data_o.order_used <= OrderW'(NumTaps))
    else $error("order out of range");

  a_short_needs_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.history_short |-> out_data_o.order_used != OrderW'(1))
    else $error("short history flagged for Euler order");

endmodule
